[design/substring_search_top_defines.svh]
// ----------------------------------------------------------------------------
// substring_search_top_defines.svh
// Assertion macros for the substring search block.
// ----------------------------------------------------------------------------
`ifndef SUBSTRING_SEARCH_TOP_DEFINES_SVH
`define SUBSTRING_SEARCH_TOP_DEFINES_SVH

// Same-cycle implication, clocked on aclk, off during reset.
`define SSS_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("substring_search: check failed");

// Next-cycle implication, clocked on aclk, off during reset.
`define SSS_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("substring_search: check failed");

`endif

[design/sss_pkg.sv]
// ----------------------------------------------------------------------------
// sss_pkg
// Shared constants and types for the substring search block.
// ----------------------------------------------------------------------------
`default_nettype none

package sss_pkg;

    localparam int PATTERN_MAX = 16;   // cells in the window chain, 1..64
    localparam int REG_BYTES   = 16;   // pattern bytes the registers hold
    localparam int PAT_LIM     = (PATTERN_MAX < REG_BYTES) ? PATTERN_MAX : REG_BYTES;
    localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
    localparam int PIDX_W      = (PAT_LIM > 1) ? $clog2(PAT_LIM) : 1;

    localparam int BYTE_W = 8;
    localparam int POS_W  = 32;
    localparam int CNT_W  = 16;
    localparam int REG_W  = 64;
    localparam int ADDR_W = 5;
    localparam int PLEN_W = 5;

    localparam logic [POS_W-1:0]  POS_MAX    = '1;
    localparam logic [CNT_W-1:0]  CNT_MAX    = '1;
    localparam logic [BYTE_W-1:0] TERMINATOR = 8'h00;

    // register index = paddr[4:3]
    localparam logic [1:0] REG_PAT_LO   = 2'd0;
    localparam logic [1:0] REG_PAT_HI   = 2'd1;
    localparam logic [1:0] REG_PAT_LEN  = 2'd2;
    localparam logic [1:0] REG_FIND_ALL = 2'd3;

    typedef logic [PAT_LIM-1:0][BYTE_W-1:0] sss_pat_t;

    typedef struct packed {
        sss_pat_t             pat;
        logic [LEN_W-1:0]     eff_len;
        logic                 find_all;
    } sss_cfg_t;

endpackage

`default_nettype wire

[design/sss_cfg.sv]
// ----------------------------------------------------------------------------
// sss_cfg
// APB register file; derives the effective pattern length.
// ----------------------------------------------------------------------------
`default_nettype none

module sss_cfg import sss_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [REG_W-1:0]  pwdata,
    output logic      [REG_W-1:0]  prdata,
    output logic                   pready,
    output sss_cfg_t               cfg
);

    logic [REG_W-1:0]  pat_lo_reg;
    logic [REG_W-1:0]  pat_hi_reg;
    logic [PLEN_W-1:0] pat_len_reg;
    logic              find_all_reg;
    logic [2*REG_W-1:0] pat_all;
    logic [LEN_W-1:0]  len_clamp;
    logic [LEN_W-1:0]  len_cut;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_lo_reg   <= '0;
            pat_hi_reg   <= '0;
            pat_len_reg  <= '0;
            find_all_reg <= 1'b0;
        end else if (wr_en) begin
            case (paddr[4:3])
                REG_PAT_LO:   pat_lo_reg   <= pwdata;
                REG_PAT_HI:   pat_hi_reg   <= pwdata;
                REG_PAT_LEN:  pat_len_reg  <= pwdata[PLEN_W-1:0];
                REG_FIND_ALL: find_all_reg <= pwdata[0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:3])
            REG_PAT_LO:   prdata = pat_lo_reg;
            REG_PAT_HI:   prdata = pat_hi_reg;
            REG_PAT_LEN:  prdata = {{(REG_W-PLEN_W){1'b0}}, pat_len_reg};
            REG_FIND_ALL: prdata = {{(REG_W-1){1'b0}}, find_all_reg};
            default:      prdata = '0;
        endcase
    end

    assign pat_all = {pat_hi_reg, pat_lo_reg};

    // length limited to the usable bytes, then cut at the first zero byte
    always_comb begin
        if (int'(pat_len_reg) > PAT_LIM) begin
            len_clamp = LEN_W'(PAT_LIM);
        end else begin
            len_clamp = LEN_W'(pat_len_reg);
        end
        len_cut = len_clamp;
        for (int i = PAT_LIM - 1; i >= 0; i--) begin
            if ((pat_all[i*BYTE_W +: BYTE_W] == TERMINATOR) && (LEN_W'(i) < len_clamp)) begin
                len_cut = LEN_W'(i);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < PAT_LIM; i++) begin
            cfg.pat[i] = pat_all[i*BYTE_W +: BYTE_W];
        end
        cfg.eff_len  = len_cut;
        cfg.find_all = find_all_reg;
    end

endmodule

`default_nettype wire

[design/sss_cell.sv]
// ----------------------------------------------------------------------------
// sss_cell
// One window slot: holds a text byte, passes it on, compares the incoming byte.
// ----------------------------------------------------------------------------
`default_nettype none

module sss_cell import sss_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              shift_en,
    input  wire logic [BYTE_W-1:0] byte_in,
    input  wire logic [BYTE_W-1:0] expected,
    input  wire logic              in_use,
    output logic      [BYTE_W-1:0] byte_out,
    output logic                   hit
);

    logic [BYTE_W-1:0] byte_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;
    // compare what this slot will hold after the shift
    assign hit = !in_use || (byte_in == expected);

endmodule

`default_nettype wire

[design/substring_search_top.sv]
// ----------------------------------------------------------------------------
// substring_search_top
// Streaming non-overlapping substring search over a zero-terminated text.
// Output: a result beat is on m_* in the cycle after the text beat that causes it.
// Throughput: one text byte per cycle; the window compare is a single pass
//   over the cell chain, so bytes go back to back while m_ready keeps up.
// Reset: aresetn (synchronous, low) clears the registers and per-text state;
//   a terminator beat clears the per-text state for the next text.
// ----------------------------------------------------------------------------
`default_nettype none

`include "substring_search_top_defines.svh"

module substring_search_top import sss_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // APB configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [REG_W-1:0]  pwdata,
    output logic      [REG_W-1:0]  prdata,
    output logic                   pready,
    // text in
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [BYTE_W-1:0] s_text_byte,
    // results out
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic      [POS_W-1:0]  m_match_offset,
    output logic                   m_found,
    output logic      [CNT_W-1:0]  m_match_count,
    output logic                   m_end_of_text
);

    sss_cfg_t cfg;

    sss_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ---------------------------------------------------------------- handshake
    logic accept;
    logic is_term;
    logic shift_en;

    logic m_valid_reg, m_valid_next;

    // single output register: take a new byte whenever the held beat leaves
    assign s_ready  = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign is_term  = (s_text_byte == TERMINATOR);
    assign shift_en = accept && !is_term;

    // ---------------------------------------------------------------- cell chain
    // Cell i holds window[i] (0 = newest). On a shift each cell checks the byte
    // it is about to take against pattern byte (len-1-i).
    logic [PATTERN_MAX-1:0][BYTE_W-1:0] chain;
    logic [PATTERN_MAX-1:0]             hits;

    for (genvar gi = 0; gi < PATTERN_MAX; gi++) begin : g_cell
        logic              in_use;
        logic [LEN_W-1:0]  sel;
        logic [BYTE_W-1:0] expected;
        logic [BYTE_W-1:0] byte_in;

        assign in_use   = (LEN_W'(gi) < cfg.eff_len);
        assign sel      = cfg.eff_len - LEN_W'(gi + 1);
        assign expected = cfg.pat[PIDX_W'(sel)];

        if (gi == 0) begin : g_head
            assign byte_in = s_text_byte;
        end else begin : g_link
            assign byte_in = chain[gi-1];
        end

        sss_cell u_cell (
            .aclk     (aclk),
            .shift_en (shift_en),
            .byte_in  (byte_in),
            .expected (expected),
            .in_use   (in_use),
            .byte_out (chain[gi]),
            .hit      (hits[gi])
        );
    end

    // ---------------------------------------------------------------- per-text state
    logic [POS_W-1:0] pos_reg,   pos_next;
    logic [LEN_W-1:0] bsr_reg,   bsr_next;      // bytes since restart, saturating
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic [POS_W-1:0] first_reg, first_next;
    logic             found_reg, found_next;

    logic [LEN_W-1:0] bsr_inc;
    logic [CNT_W-1:0] cnt_inc;
    logic [POS_W-1:0] start_pos;
    logic             match;

    assign bsr_inc = (bsr_reg < LEN_W'(PATTERN_MAX)) ? bsr_reg + 1'b1 : bsr_reg;
    assign cnt_inc = (cnt_reg != CNT_MAX) ? cnt_reg + 1'b1 : cnt_reg;

    // match start; pinned at the top once the position has saturated
    assign start_pos = (pos_reg == POS_MAX) ? POS_MAX
                     : pos_reg - POS_W'(cfg.eff_len) + POS_W'(1);

    // first mode stops looking after one match
    assign match = shift_en
                && (cfg.eff_len != '0)
                && (cfg.find_all || !found_reg)
                && (bsr_inc >= cfg.eff_len)
                && (&hits);

    always_comb begin
        pos_next   = pos_reg;
        bsr_next   = bsr_reg;
        cnt_next   = cnt_reg;
        first_next = first_reg;
        found_next = found_reg;
        if (accept && is_term) begin
            pos_next   = '0;
            bsr_next   = '0;
            cnt_next   = '0;
            first_next = '0;
            found_next = 1'b0;
        end else if (shift_en) begin
            if (pos_reg != POS_MAX) begin
                pos_next = pos_reg + 1'b1;
            end
            bsr_next = bsr_inc;
            if (match) begin
                bsr_next = '0;       // restart right after the match
                cnt_next = cnt_inc;
                if (!found_reg) begin
                    first_next = start_pos;
                    found_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            bsr_reg   <= '0;
            cnt_reg   <= '0;
            first_reg <= '0;
            found_reg <= 1'b0;
        end else begin
            pos_reg   <= pos_next;
            bsr_reg   <= bsr_next;
            cnt_reg   <= cnt_next;
            first_reg <= first_next;
            found_reg <= found_next;
        end
    end

    // ---------------------------------------------------------------- result register
    logic [POS_W-1:0] off_reg, off_next;
    logic             fnd_reg, fnd_next;
    logic [CNT_W-1:0] mcnt_reg, mcnt_next;
    logic             eot_reg, eot_next;

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        off_next     = off_reg;
        fnd_next     = fnd_reg;
        mcnt_next    = mcnt_reg;
        eot_next     = eot_reg;
        if (accept && is_term) begin
            // summary beat; an empty pattern counts as found at offset zero
            m_valid_next = 1'b1;
            eot_next     = 1'b1;
            if (cfg.eff_len == '0) begin
                off_next  = '0;
                fnd_next  = 1'b1;
                mcnt_next = '0;
            end else begin
                off_next  = first_reg;
                fnd_next  = found_reg;
                mcnt_next = cnt_reg;
            end
        end else if (match) begin
            m_valid_next = 1'b1;
            eot_next     = 1'b0;
            off_next     = start_pos;
            fnd_next     = 1'b1;
            mcnt_next    = cnt_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        off_reg  <= off_next;
        fnd_reg  <= fnd_next;
        mcnt_reg <= mcnt_next;
        eot_reg  <= eot_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_match_offset = off_reg;
    assign m_found        = fnd_reg;
    assign m_match_count  = mcnt_reg;
    assign m_end_of_text  = eot_reg;

    // ---------------------------------------------------------------- checks
    // a match beat always carries found and a nonzero count
    `SSS_ASSERT_IMP(a_match_beat_found, m_valid && !m_end_of_text, m_found)
    `SSS_ASSERT_IMP(a_match_beat_count, m_valid && !m_end_of_text, m_match_count != '0)
    // a terminator leaves the per-text state cleared
    `SSS_ASSERT_NXT(a_term_clears, accept && is_term,
                    pos_reg == '0 && bsr_reg == '0 && cnt_reg == '0 && !found_reg)

endmodule

`default_nettype wire

[test/substring_search_checker.sv]
// ----------------------------------------------------------------------------
// substring_search_checker
// Watches the config bus and both beat channels of the substring search
// block, predicts each result beat and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module substring_search_checker import sss_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [REG_W-1:0]  pwdata,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [BYTE_W-1:0] s_text_byte,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [POS_W-1:0]  m_match_offset,
    input  logic              m_found,
    input  logic [CNT_W-1:0]  m_match_count,
    input  logic              m_end_of_text,
    output int                mismatches,
    output int                pending
);

    typedef struct packed {
        logic [POS_W-1:0] offset;
        logic             found;
        logic [CNT_W-1:0] count;
        logic             eot;
    } search_result_t;

    // register copies
    logic [REG_W-1:0]  pat_lo;
    logic [REG_W-1:0]  pat_hi;
    logic [PLEN_W-1:0] pat_len;
    logic              find_all_mode;

    // per-text state
    logic [BYTE_W-1:0] window [PATTERN_MAX];
    logic [POS_W-1:0]  text_pos;
    int                since_restart;
    logic [CNT_W-1:0]  hit_count;
    logic [POS_W-1:0]  first_hit;
    logic              any_hit;

    search_result_t expected_hits[$];
    search_result_t want;

    function automatic logic [BYTE_W-1:0] pat_byte(input int i);
        if (i < 8)
            return pat_lo[8*i +: 8];
        if (i < REG_BYTES)
            return pat_hi[8*(i-8) +: 8];
        return '0;
    endfunction

    // Pattern is a C string: length is clipped to the register space and cut
    // at the first zero byte.
    function automatic int active_length();
        int n;
        n = int'(pat_len);
        if (n > PATTERN_MAX)
            n = PATTERN_MAX;
        if (n > REG_BYTES)
            n = REG_BYTES;
        for (int i = 0; i < n; i++)
            if (pat_byte(i) == TERMINATOR)
                return i;
        return n;
    endfunction

    task automatic clear_text();
        for (int i = 0; i < PATTERN_MAX; i++)
            window[i] = '0;
        text_pos      = '0;
        since_restart = 0;
        hit_count     = '0;
        first_hit     = '0;
        any_hit       = 1'b0;
    endtask

    task automatic predict_text_byte(input logic [BYTE_W-1:0] b);
        int               len;
        logic             hit;
        logic [POS_W-1:0] idx;
        logic [POS_W-1:0] start;
        search_result_t   r;
        len = active_length();
        if (b == TERMINATOR) begin
            if (len == 0) begin
                r.offset = '0;
                r.found  = 1'b1;
                r.count  = '0;
            end else begin
                r.offset = any_hit ? first_hit : '0;
                r.found  = any_hit;
                r.count  = hit_count;
            end
            r.eot = 1'b1;
            expected_hits.push_back(r);
            clear_text();
            return;
        end
        idx = text_pos;
        if (text_pos != POS_MAX)
            text_pos = text_pos + 1'b1;
        for (int i = PATTERN_MAX - 1; i > 0; i--)
            window[i] = window[i-1];
        window[0] = b;
        if (since_restart < PATTERN_MAX)
            since_restart++;
        if (len == 0 || (!find_all_mode && any_hit) || since_restart < len)
            return;
        hit = 1'b1;
        for (int i = 0; i < len; i++)
            if (window[i] != pat_byte(len - 1 - i))
                hit = 1'b0;
        if (!hit)
            return;
        start = (idx == POS_MAX) ? POS_MAX : idx - POS_W'(len - 1);
        if (!any_hit) begin
            first_hit = start;
            any_hit   = 1'b1;
        end
        if (hit_count != CNT_MAX)
            hit_count = hit_count + 1'b1;
        since_restart = 0;
        r.offset = start;
        r.found  = 1'b1;
        r.count  = hit_count;
        r.eot    = 1'b0;
        expected_hits.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] want_v,
                                   input logic [63:0] got_v);
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
    endtask

    initial begin
        mismatches = 0;
        pending    = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            pat_lo        = '0;
            pat_hi        = '0;
            pat_len       = '0;
            find_all_mode = 1'b0;
            clear_text();
            expected_hits.delete();
        end else begin
            if (s_valid && s_ready)
                predict_text_byte(s_text_byte);
            if (m_valid && m_ready) begin
                if (expected_hits.size() == 0) begin
                    report_mismatch("unexpected result beat, offset", '0,
                                    64'(m_match_offset));
                end else begin
                    want = expected_hits.pop_front();
                    if (m_match_offset !== want.offset)
                        report_mismatch("match_offset", 64'(want.offset),
                                        64'(m_match_offset));
                    if (m_found !== want.found)
                        report_mismatch("found", 64'(want.found), 64'(m_found));
                    if (m_match_count !== want.count)
                        report_mismatch("match_count", 64'(want.count),
                                        64'(m_match_count));
                    if (m_end_of_text !== want.eot)
                        report_mismatch("end_of_text", 64'(want.eot),
                                        64'(m_end_of_text));
                end
            end
            // new settings apply from the next text beat on
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:3])
                    REG_PAT_LO:   pat_lo = pwdata;
                    REG_PAT_HI:   pat_hi = pwdata;
                    REG_PAT_LEN:  pat_len = pwdata[PLEN_W-1:0];
                    REG_FIND_ALL: find_all_mode = pwdata[0];
                    default: ;
                endcase
            end
        end
        pending = expected_hits.size();
    end

endmodule

[test/tb_substring_search_top.sv]
// ----------------------------------------------------------------------------
// tb_substring_search_top
// Drives text beats and register writes into the substring search block:
// a short directed pass over the corner cases, then random patterns and
// texts built around them.
// The checker beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_substring_search_top;
    import sss_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat, no bus write
    localparam int RANDOM_BYTES   = 1480;  // total text beats, directed ones included

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [REG_W-1:0]  pwdata;
    logic [REG_W-1:0]  prdata;
    logic              pready;
    logic              s_valid;
    logic              s_ready;
    logic [BYTE_W-1:0] s_text_byte;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [POS_W-1:0]  m_match_offset;
    logic              m_found;
    logic [CNT_W-1:0]  m_match_count;
    logic              m_end_of_text;

    int mismatches;
    int pending;

    // stimulus-side view of the pattern, used only to plant matches in texts
    logic [BYTE_W-1:0] needle[$];

    int   burst_left  = 0;
    logic gapless     = 1'b0;
    int   sent_bytes  = 0;
    int   rcv_mode    = 0;
    int   rcv_left    = 0;
    int   idle_cycles = 0;

    substring_search_top DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_text_byte    (s_text_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_match_offset (m_match_offset),
        .m_found        (m_found),
        .m_match_count  (m_match_count),
        .m_end_of_text  (m_end_of_text)
    );

    substring_search_checker hit_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_text_byte    (s_text_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_match_offset (m_match_offset),
        .m_found        (m_found),
        .m_match_count  (m_match_count),
        .m_end_of_text  (m_end_of_text),
        .mismatches     (mismatches),
        .pending        (pending)
    );

    always #6 aclk = ~aclk;

    // Result side backpressure. Each stretch picks one behavior: always
    // ready, light stalls, coin flip, or mostly stalled (long stall runs).
    always @(negedge aclk) begin
        if (rcv_left == 0) begin
            rcv_mode = $urandom_range(0, 3);
            rcv_left = $urandom_range(20, 200);
        end
        rcv_left--;
        case (rcv_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= ($urandom_range(0, 3) != 0);
            2:       m_ready <= $urandom_range(0, 1);
            default: m_ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    // Watchdog: any beat or register write restarts the count.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable && pready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // All tasks below start and end on a falling edge.

    // Two-phase bus write: setup, then access until pready.
    task automatic apb_write(input logic [1:0] idx, input logic [REG_W-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_W'({idx, 3'b000});
        pwdata  = data;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Hold the text side until every predicted result has come out, then a
    // few more cycles so a byte without a result is surely through the block.
    task automatic wait_drained();
        do @(negedge aclk); while (pending != 0);
        repeat (4) @(negedge aclk);
    endtask

    // One text beat. Outside gapless stretches the sender runs in bursts with
    // short gaps, now and then a long one.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        if (!gapless && burst_left == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 30 : 4))
                @(negedge aclk);
            burst_left = $urandom_range(1, 24);
        end
        s_valid     = 1'b1;
        s_text_byte = b;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        // dropped here, raised again right away if another beat follows
        s_valid = 1'b0;
        if (burst_left > 0)
            burst_left--;
        sent_bytes++;
    endtask

    task automatic send_string(input string txt);
        for (int i = 0; i < txt.len(); i++)
            send_byte(txt[i]);
    endtask

    // Writes all four registers while the block is drained; this is also
    // where the sender pauses for every outstanding result. When the last
    // text was left open, the change lands mid-text.
    task automatic set_config(input logic [REG_W-1:0] lo, input logic [REG_W-1:0] hi,
                              input logic [PLEN_W-1:0] len, input logic all_mode);
        logic [BYTE_W-1:0] b;
        wait_drained();
        apb_write(REG_PAT_LO, lo);
        apb_write(REG_PAT_HI, hi);
        apb_write(REG_PAT_LEN, REG_W'(len));
        apb_write(REG_FIND_ALL, REG_W'(all_mode));
        needle.delete();
        for (int i = 0; i < len && i < PAT_LIM; i++) begin
            b = (i < 8) ? lo[8*i +: 8] : hi[8*(i-8) +: 8];
            if (b == TERMINATOR)
                break;
            needle.push_back(b);
        end
    endtask

    // Random pattern: mostly short over a tiny alphabet so that texts hit
    // often; sometimes full length, an oversized length, wide byte values,
    // or a zero byte that cuts the pattern short.
    task automatic random_config();
        logic [REG_W-1:0]  lo;
        logic [REG_W-1:0]  hi;
        logic [BYTE_W-1:0] b;
        int                len;
        int                r;
        logic              wide;
        lo   = {$urandom, $urandom};
        hi   = {$urandom, $urandom};
        wide = ($urandom_range(0, 9) < 3);
        r    = $urandom_range(0, 19);
        if (r == 0)
            len = 0;
        else if (r == 1)
            len = 16;
        else if (r == 2)
            len = $urandom_range(17, 31);
        else if (r < 12)
            len = $urandom_range(1, 3);
        else
            len = $urandom_range(4, 15);
        for (int i = 0; i < len && i < REG_BYTES; i++) begin
            b = wide ? BYTE_W'($urandom_range(1, 255)) : BYTE_W'(8'h61 + $urandom_range(0, 2));
            if (i < 8)
                lo[8*i +: 8] = b;
            else
                hi[8*(i-8) +: 8] = b;
        end
        if (len > 1 && $urandom_range(0, 19) == 0) begin
            r = $urandom_range(0, ((len < REG_BYTES) ? len : REG_BYTES) - 1);
            if (r < 8)
                lo[8*r +: 8] = TERMINATOR;
            else
                hi[8*(r-8) +: 8] = TERMINATOR;
        end
        set_config(lo, hi, PLEN_W'(len), ($urandom_range(0, 2) != 0));
    endtask

    // Filler: pattern bytes, a small alphabet, or any non-zero byte.
    function automatic logic [BYTE_W-1:0] pick_filler();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return BYTE_W'($urandom_range(1, 255));
        if (r < 6 && needle.size() > 0)
            return needle[$urandom_range(0, needle.size() - 1)];
        return BYTE_W'(8'h61 + $urandom_range(0, 2));
    endfunction

    // Text with planted whole matches, broken prefixes and filler; most
    // texts are short, some long. An open text runs on into the next one.
    task automatic send_random_text(input logic close_text);
        int n;
        int k;
        int r;
        int m;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 30);
        k = 0;
        while (k < n) begin
            r = $urandom_range(0, 9);
            if (r < 3 && needle.size() > 0) begin
                foreach (needle[j])
                    send_byte(needle[j]);
                k += needle.size();
            end else if (r < 5 && needle.size() > 1) begin
                m = $urandom_range(1, needle.size() - 1);
                for (int j = 0; j < m; j++)
                    send_byte(needle[j]);
                k += m;
            end else begin
                send_byte(pick_filler());
                k++;
            end
        end
        if (close_text)
            send_byte(TERMINATOR);
    endtask

    initial begin
        aresetn     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        s_valid     = 1'b0;
        s_text_byte = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part, back to back.
        gapless = 1'b1;
        // registers still at reset: empty pattern on an empty text
        send_byte(TERMINATOR);
        // first mode: only the match at 0, count stays 1
        set_config(64'h6161, '0, 5'd2, 1'b0);
        send_string("aaaa");
        send_byte(TERMINATOR);
        // all mode: restart after each hit gives 0 and 2, no overlap
        set_config(64'h6161, '0, 5'd2, 1'b1);
        send_string("aaaa");
        send_byte(TERMINATOR);
        // zero byte inside the pattern cuts it to a single 'q'
        set_config(64'h7A7A_0071, '0, 5'd4, 1'b1);
        send_string("zq");
        send_byte(TERMINATOR);
        // oversized length clipped to 16, all-ones pattern and text bytes
        set_config('1, '1, 5'd31, 1'b0);
        repeat (16) send_byte(8'hFF);
        send_byte(TERMINATOR);

        // Random part: a new setting per phase, a few texts per setting.
        while (sent_bytes < RANDOM_BYTES) begin
            random_config();
            gapless = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 4))
                send_random_text($urandom_range(0, 9) != 0);
        end
        send_byte(TERMINATOR);

        wait_drained();
        repeat (8) @(negedge aclk);
        if (mismatches == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
